// ===== rtl/epd_pkg.sv =====
// ----------------------------------------------------------------------------
// epd_pkg
// types, constants and the crc-8 byte update shared by the deframer files
// ----------------------------------------------------------------------------
package epd_pkg;

    localparam int unsigned LENGTH_BITS_DEF = 24;
    localparam int unsigned LEN_FIELD_BITS  = 24;
    localparam int unsigned LEN_LO_BITS     = 16;

    localparam logic [7:0] ESC_BYTE = 8'd27;
    localparam logic [7:0] ESC_HDR  = 8'd28;
    localparam logic [7:0] CRC_POLY = 8'h91;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_TYPE   = 3'd1,
        PH_LEN0   = 3'd2,
        PH_LEN1   = 3'd3,
        PH_LEN2   = 3'd4,
        PH_DATA   = 3'd5,
        PH_CRC    = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_GOOD = 2'd1,
        KIND_BAD  = 2'd2
    } kind_t;

    // lsb-first crc-8, one byte
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = c ^ CRC_POLY;
            end
            c = c >> 1;
        end
        return c;
    endfunction

endpackage

// ===== rtl/epd_rx_if.sv =====
// ----------------------------------------------------------------------------
// epd_rx_if
// valid/ready channel carrying one received raw byte
// ----------------------------------------------------------------------------
interface epd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/epd_res_if.sv =====
// ----------------------------------------------------------------------------
// epd_res_if
// valid/ready channel carrying one deframer result
// ----------------------------------------------------------------------------
interface epd_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [7:0]  frame_type;
    logic [23:0] payload_length;
    logic        last;

    modport source (output valid, output kind, output data_byte, output frame_type,
                    output payload_length, output last, input ready);
    modport sink   (input valid, input kind, input data_byte, input frame_type,
                    input payload_length, input last, output ready);
endinterface

// ===== rtl/escaped_packet_deframer_crc_core.sv =====
// ----------------------------------------------------------------------------
// escaped_packet_deframer_crc_core
// header hunt, unescape and crc-8 check of a byte-stuffed packet stream
// ----------------------------------------------------------------------------
// the result of an rx transfer is registered in the output register
// throughput: one byte per cycle while the output register is not stalled
// rx is held off only while a result waits in the output register
// reset: asynchronous, phase back to header hunt, header byte and counters zero
// ----------------------------------------------------------------------------
module escaped_packet_deframer_crc_core #(
    parameter int unsigned LENGTH_BITS = epd_pkg::LENGTH_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic [7:0]     cfg_data,
    epd_rx_if.sink         rx,
    epd_res_if.source      res
);
    import epd_pkg::*;

    logic [7:0]                header_byte_reg;
    phase_t                    phase_reg, phase_next;
    logic [7:0]                type_reg, type_next;
    logic [LEN_LO_BITS-1:0]    len_lo_reg, len_lo_next;
    logic [LENGTH_BITS-1:0]    raw_length_reg, raw_length_next;
    logic [LENGTH_BITS-1:0]    raw_count_reg, raw_count_next;
    logic [LENGTH_BITS-1:0]    out_count_reg, out_count_next;
    logic [7:0]                crc_reg, crc_next;
    logic                      esc_reg, esc_next;

    logic                      res_valid_reg;
    logic [1:0]                res_kind_reg;
    logic [7:0]                res_data_reg;
    logic [7:0]                res_type_reg;
    logic [LEN_FIELD_BITS-1:0] res_len_reg;
    logic                      res_last_reg;

    logic                      emit;
    kind_t                     emit_kind;
    logic [7:0]                emit_data;
    logic                      emit_last;

    logic                      accept;
    logic [7:0]                b;
    logic [7:0]                crc_upd;
    logic [LEN_FIELD_BITS-1:0] len_full;
    logic [LENGTH_BITS:0]      raw_count_inc;

    assign rx.ready      = !res_valid_reg || res.ready;
    assign accept        = rx.valid && rx.ready;
    assign b             = rx.rx_byte;
    assign crc_upd       = crc8_byte(crc_reg, b);
    assign len_full      = {b, len_lo_reg};
    assign raw_count_inc = {1'b0, raw_count_reg} + {{LENGTH_BITS{1'b0}}, 1'b1};

    // next state
    always_comb
    begin
        phase_next      = phase_reg;
        type_next       = type_reg;
        len_lo_next     = len_lo_reg;
        raw_length_next = raw_length_reg;
        raw_count_next  = raw_count_reg;
        out_count_next  = out_count_reg;
        crc_next        = crc_reg;
        esc_next        = esc_reg;
        unique case (phase_reg)
            PH_HEADER:
            begin
                if (b == header_byte_reg)
                begin
                    phase_next = PH_TYPE;
                end
            end
            PH_TYPE:
            begin
                type_next  = b;
                crc_next   = crc8_byte(8'd0, b);
                phase_next = PH_LEN0;
            end
            PH_LEN0:
            begin
                len_lo_next[7:0] = b;
                crc_next         = crc_upd;
                phase_next       = PH_LEN1;
            end
            PH_LEN1:
            begin
                len_lo_next[15:8] = b;
                crc_next          = crc_upd;
                phase_next        = PH_LEN2;
            end
            PH_LEN2:
            begin
                raw_length_next = len_full[LENGTH_BITS-1:0];
                crc_next        = crc_upd;
                raw_count_next  = '0;
                out_count_next  = '0;
                esc_next        = 1'b0;
                phase_next      = (len_full[LENGTH_BITS-1:0] == '0) ? PH_CRC : PH_DATA;
            end
            PH_DATA:
            begin
                crc_next       = crc_upd;
                raw_count_next = raw_count_inc[LENGTH_BITS-1:0];
                if (esc_reg || b != ESC_BYTE)
                begin
                    esc_next       = 1'b0;
                    out_count_next = out_count_reg + {{(LENGTH_BITS-1){1'b0}}, 1'b1};
                end
                else
                begin
                    esc_next = 1'b1;
                end
                if (raw_count_inc >= {1'b0, raw_length_reg})
                begin
                    esc_next   = 1'b0;
                    phase_next = PH_CRC;
                end
            end
            PH_CRC:
            begin
                phase_next = PH_HEADER;
            end
            default:
            begin
                phase_next = PH_HEADER;
            end
        endcase
    end

    // result
    always_comb
    begin
        emit      = 1'b0;
        emit_kind = KIND_DATA;
        emit_data = 8'd0;
        emit_last = 1'b0;
        unique case (phase_reg)
            PH_DATA:
            begin
                if (esc_reg)
                begin
                    emit      = 1'b1;
                    emit_data = (b == ESC_HDR) ? header_byte_reg : b;
                end
                else if (b != ESC_BYTE)
                begin
                    emit      = 1'b1;
                    emit_data = b;
                end
            end
            PH_CRC:
            begin
                emit      = 1'b1;
                emit_kind = (crc_reg == b) ? KIND_GOOD : KIND_BAD;
                emit_last = 1'b1;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_byte_reg <= 8'd0;
            phase_reg       <= PH_HEADER;
            type_reg        <= 8'd0;
            len_lo_reg      <= '0;
            raw_length_reg  <= '0;
            raw_count_reg   <= '0;
            out_count_reg   <= '0;
            crc_reg         <= 8'd0;
            esc_reg         <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                header_byte_reg <= cfg_data;
            end
            if (accept)
            begin
                phase_reg      <= phase_next;
                type_reg       <= type_next;
                len_lo_reg     <= len_lo_next;
                raw_length_reg <= raw_length_next;
                raw_count_reg  <= raw_count_next;
                out_count_reg  <= out_count_next;
                crc_reg        <= crc_next;
                esc_reg        <= esc_next;
                res_valid_reg  <= emit;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded on every rx transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_kind_reg <= emit_kind;
            res_data_reg <= emit_data;
            res_type_reg <= type_reg;
            res_last_reg <= emit_last;
            res_len_reg  <= emit_last ? LEN_FIELD_BITS'(out_count_reg) : '0;
        end
    end

    assign res.valid          = res_valid_reg;
    assign res.kind           = res_kind_reg;
    assign res.data_byte      = res_data_reg;
    assign res.frame_type     = res_type_reg;
    assign res.payload_length = res_len_reg;
    assign res.last           = res_last_reg;

`ifndef SYNTHESIS
    a_stall_blocks_rx: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.ready) |-> !rx.ready)
        else $error("rx accepted while a result is stalled");

    a_crc_byte_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && phase_reg == PH_CRC) |=> (res.valid && res.last))
        else $error("crc byte did not produce an end result");

    a_data_result_form: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.last) |-> (res.kind == KIND_DATA && res.payload_length == '0))
        else $error("malformed data result");

    a_end_result_form: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.last) |-> (res.data_byte == 8'd0 &&
            (res.kind == KIND_GOOD || res.kind == KIND_BAD)))
        else $error("malformed end result");
`endif

endmodule

// ===== bench/escaped_packet_deframer_crc_core_tb.sv =====
// ----------------------------------------------------------------------------
// escaped_packet_deframer_crc_core_tb
// drives escaped, crc-protected packets, noise and cut-short frames into the
// deframer under random idling and stalls, predicts every data byte and end
// verdict, and compares each result transfer field by field in order
// ----------------------------------------------------------------------------
module escaped_packet_deframer_crc_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import epd_pkg::*;

    localparam int unsigned LEN_BITS      = LENGTH_BITS_DEF;
    localparam logic [23:0] LEN_MASK      = 24'((64'd1 << LEN_BITS) - 64'd1);
    localparam logic [7:0]  CRC_HALF_POLY = CRC_POLY >> 1;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned BIG_LENGTH    = 290;
    localparam int unsigned HALF_ITEMS    = 215;

    typedef logic [7:0] byte_q_t[$];

    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic [7:0]  frame_type;
        logic [23:0] payload_length;
        logic        last;
    } deframe_result_t;

    class deframe_tracker;
        logic [7:0]      header_byte;
        phase_t          phase;
        logic [7:0]      type_reg;
        logic [23:0]     raw_length;
        logic [23:0]     raw_count;
        logic [23:0]     out_count;
        logic [7:0]      crc_acc;
        bit              escape_pending;
        deframe_result_t expected_results[$];
        int unsigned     mismatch_count;

        function new();
            header_byte    = 8'd0;
            phase          = PH_HEADER;
            type_reg       = 8'd0;
            raw_length     = 24'd0;
            raw_count      = 24'd0;
            out_count      = 24'd0;
            crc_acc        = 8'd0;
            escape_pending = 1'b0;
            mismatch_count = 0;
        endfunction

        // lsb-first, polynomial folded into the shift
        static function logic [7:0] crc_step(logic [7:0] crc, logic [7:0] b);
            logic [7:0] c;
            c = crc ^ b;
            repeat (8)
            begin
                c = (c >> 1) ^ (c[0] ? CRC_HALF_POLY : 8'h00);
            end
            return c;
        endfunction

        function void push_result(kind_t k, logic [7:0] d, logic [23:0] n, logic l);
            deframe_result_t r;
            r.kind           = k;
            r.data_byte      = d;
            r.frame_type     = type_reg;
            r.payload_length = n;
            r.last           = l;
            expected_results.push_back(r);
        endfunction

        function void note_rx_byte(logic [7:0] b);
            case (phase)
                PH_HEADER:
                begin
                    if (b == header_byte)
                    begin
                        phase = PH_TYPE;
                    end
                end
                PH_TYPE:
                begin
                    type_reg = b;
                    crc_acc  = crc_step(8'd0, b);
                    phase    = PH_LEN0;
                end
                PH_LEN0:
                begin
                    raw_length = {16'd0, b};
                    crc_acc    = crc_step(crc_acc, b);
                    phase      = PH_LEN1;
                end
                PH_LEN1:
                begin
                    raw_length = raw_length | {8'd0, b, 8'd0};
                    crc_acc    = crc_step(crc_acc, b);
                    phase      = PH_LEN2;
                end
                PH_LEN2:
                begin
                    raw_length     = (raw_length | {b, 16'd0}) & LEN_MASK;
                    crc_acc        = crc_step(crc_acc, b);
                    raw_count      = 24'd0;
                    out_count      = 24'd0;
                    escape_pending = 1'b0;
                    phase          = (raw_length == 24'd0) ? PH_CRC : PH_DATA;
                end
                PH_DATA:
                begin
                    crc_acc   = crc_step(crc_acc, b);
                    raw_count = raw_count + 24'd1;
                    if (escape_pending)
                    begin
                        escape_pending = 1'b0;
                        push_result(KIND_DATA, (b == ESC_HDR) ? header_byte : b, 24'd0, 1'b0);
                        out_count = out_count + 24'd1;
                    end
                    else if (b == ESC_BYTE)
                    begin
                        escape_pending = 1'b1;
                    end
                    else
                    begin
                        push_result(KIND_DATA, b, 24'd0, 1'b0);
                        out_count = out_count + 24'd1;
                    end
                    // a lone escape at the end is dropped
                    if (raw_count >= raw_length)
                    begin
                        escape_pending = 1'b0;
                        phase          = PH_CRC;
                    end
                end
                PH_CRC:
                begin
                    push_result((crc_acc == b) ? KIND_GOOD : KIND_BAD, 8'd0, out_count, 1'b1);
                    phase = PH_HEADER;
                end
                default:
                begin
                    phase = PH_HEADER;
                end
            endcase
        endfunction

        function void compare_field(string name, logic [23:0] want, logic [23:0] got);
            if (want !== got)
            begin
                mismatch_count++;
                $error("%s: expected %0d actual %0d", name, want, got);
            end
        endfunction

        function void check_result(deframe_result_t got);
            deframe_result_t want;
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                $error("unexpected result: kind %0d data_byte %0d", got.kind, got.data_byte);
                return;
            end
            want = expected_results.pop_front();
            compare_field("kind", want.kind, got.kind);
            compare_field("data_byte", want.data_byte, got.data_byte);
            compare_field("frame_type", want.frame_type, got.frame_type);
            compare_field("payload_length", want.payload_length, got.payload_length);
            compare_field("last", want.last, got.last);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [7:0]  cfg_data;

    epd_rx_if  rx_ch();
    epd_res_if res_ch();

    deframe_tracker tracker = new();

    int unsigned send_gap_pct;
    int unsigned take_stall_pct;
    bit          hold_armed;
    int unsigned framed_bytes;
    logic [7:0]  cur_header;

    escaped_packet_deframer_crc_core #(
        .LENGTH_BITS(LEN_BITS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg_we  (cfg_we),
        .cfg_data(cfg_data),
        .rx      (rx_ch),
        .res     (res_ch)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin : result_side
        int unsigned     held;
        deframe_result_t got;
        held = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_ch.valid && res_ch.ready)
            begin
                got.kind           = res_ch.kind;
                got.data_byte      = res_ch.data_byte;
                got.frame_type     = res_ch.frame_type;
                got.payload_length = res_ch.payload_length;
                got.last           = res_ch.last;
                tracker.check_result(got);
            end
            // long hold-off so the output register fills and rx backs up
            if (hold_armed && held < HOLD_CYCLES)
            begin
                held++;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= ($urandom_range(99) >= take_stall_pct);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_gap_pct)
        begin
            rx_ch.valid <= 1'b0;
            @(posedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge clk);
        while (!rx_ch.ready)
        begin
            @(posedge clk);
        end
        tracker.note_rx_byte(b);
    endtask

    // cut == 0 sends the whole frame, otherwise only its first cut bytes if cut is shorter than the frame
    task automatic send_frame(input logic [7:0] ftype, input byte_q_t raw, input bit bad_crc,
                              input int unsigned cut);
        byte_q_t     frame;
        logic [23:0] n;
        logic [7:0]  crc;
        n = 24'(raw.size());
        frame = {cur_header, ftype, n[7:0], n[15:8], n[23:16]};
        crc = 8'd0;
        for (int i = 1; i < 5; i++)
        begin
            crc = deframe_tracker::crc_step(crc, frame[i]);
        end
        foreach (raw[i])
        begin
            crc = deframe_tracker::crc_step(crc, raw[i]);
            frame.push_back(raw[i]);
        end
        if (bad_crc)
        begin
            crc = crc ^ 8'($urandom_range(1, 255));
        end
        frame.push_back(crc);
        if (cut != 0 && cut < frame.size())
        begin
            frame = frame[0:cut - 1];
        end
        foreach (frame[i])
        begin
            send_byte(frame[i]);
        end
        framed_bytes += frame.size();
    endtask

    function automatic byte_q_t make_raw(int unsigned n);
        byte_q_t     raw;
        int unsigned r;
        for (int unsigned i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < 12)
            begin
                raw.push_back(ESC_BYTE);
            end
            else if (r < 18)
            begin
                raw.push_back(ESC_HDR);
            end
            else if (r < 24)
            begin
                raw.push_back(cur_header);
            end
            else
            begin
                raw.push_back(8'($urandom));
            end
        end
        return raw;
    endfunction

    task automatic wait_idle();
        rx_ch.valid <= 1'b0;
        @(posedge clk);
        while (tracker.expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_header(input logic [7:0] value);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        tracker.header_byte = value;
        cur_header = value;
    endtask

    task automatic random_traffic(input int unsigned target);
        int unsigned stop_at;
        int unsigned r;
        int unsigned len;
        stop_at = framed_bytes + target;
        while (framed_bytes < stop_at)
        begin
            r = $urandom_range(99);
            if (r < 8)
            begin
                // noise bytes between frames
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
            end
            else
            begin
                len = $urandom_range(99);
                if (len < 12)
                begin
                    len = 0;
                end
                else if (len < 16)
                begin
                    len = 256 + $urandom_range(40);
                end
                else
                begin
                    len = $urandom_range(1, 24);
                end
                send_frame(8'($urandom), make_raw(len), $urandom_range(99) < 20,
                           (r < 16) ? $urandom_range(5, len + 5) : 0);
            end
        end
    endtask

    task automatic run_phase(input int unsigned gap_pct, input int unsigned stall_pct,
                             input logic [7:0] hdr_a, input logic [7:0] hdr_b);
        send_gap_pct   = gap_pct;
        take_stall_pct = stall_pct;
        write_header(hdr_a);
        random_traffic(HALF_ITEMS);
        wait_idle();
        write_header(hdr_b);
        random_traffic(HALF_ITEMS);
        wait_idle();
    endtask

    initial
    begin : stimulus
        byte_q_t raw;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_data       = 8'd0;
        rx_ch.valid    = 1'b0;
        rx_ch.rx_byte  = 8'd0;
        send_gap_pct   = 0;
        take_stall_pct = 0;
        hold_armed     = 1'b0;
        framed_bytes   = 0;
        cur_header     = 8'd0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // header still at reset value
        send_byte(8'hFF);
        raw.delete();
        send_frame(8'hFF, raw, 1'b0, 0);
        raw = {ESC_BYTE, ESC_HDR, ESC_BYTE, 8'hFF};
        send_frame(8'h00, raw, 1'b1, 0);
        raw = {8'h00, cur_header, ESC_BYTE};
        send_frame(8'hA5, raw, 1'b0, 0);
        wait_idle();

        run_phase(26, 80, 8'hFF, 8'($urandom));
        run_phase(80, 26, ESC_BYTE, ESC_HDR);

        send_gap_pct   = 0;
        take_stall_pct = 0;
        write_header(8'h00);
        hold_armed = 1'b1;
        random_traffic(HALF_ITEMS);
        wait_idle();
        write_header(8'($urandom));
        send_frame(8'h5A, make_raw(BIG_LENGTH), 1'b0, 0);
        random_traffic(HALF_ITEMS);
        wait_idle();

        if (tracker.mismatch_count == 0)
        begin
            $display("escaped_packet_deframer_crc_core_tb: done, clean");
        end
        else
        begin
            $display("escaped_packet_deframer_crc_core_tb: done, errors");
        end
        $finish;
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("escaped_packet_deframer_crc_core_tb: done, errors");
        $finish;
    end

endmodule
